// ===== sv/rri_pkg.sv =====
// shared types and constants for the ray/rectangle intersection block
`timescale 1ns / 1ps
package rri_pkg;

  localparam int QBITS = 31;
  localparam int ALOW = 15;
  localparam logic [QBITS-1:0] T_MAX = '1;

  localparam logic [2:0] REG_NORMAL_X = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;
  localparam logic [2:0] REG_CENTER_Z = 3'd5;
  localparam logic [2:0] REG_HALF_W = 3'd6;
  localparam logic [2:0] REG_HALF_H = 3'd7;

  typedef struct packed {
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
  } res_t;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        half_width;
    logic [30:0]        half_height;
  } conf_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic             sat;
    logic [63:0]      r;
    logic [ALOW-1:0]  al;
    logic [63:0]      b;
    logic [QBITS-1:0] q;
    ray_t             ray;
  } div_beat_t;

endpackage

// ===== sv/rri_front.sv =====
// products, plane sums, magnitudes and saturation check ahead of the divider
`timescale 1ns / 1ps
module rri_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  rri_pkg::ray_t     ray,
  input  rri_pkg::conf_t    conf,
  output rri_pkg::div_beat_t beat
);
  import rri_pkg::*;

  logic v1_r, v2_r, v3_r;
  ray_t ray1_r, ray2_r, ray3_r;
  logic signed [63:0] pc_r [3];
  logic signed [63:0] po_r [3];
  logic signed [63:0] pv_r [3];
  logic signed [66:0] nc_r, no_r, num_r;
  logic signed [65:0] den2_r, den_r;
  div_beat_t beat_r, beat_nxt;
  logic [65:0] a;
  logic [63:0] b;
  logic [65:0] den_abs;

  always_ff @(posedge clk) begin
    pc_r[0] <= conf.normal_x * conf.center_x;
    pc_r[1] <= conf.normal_y * conf.center_y;
    pc_r[2] <= conf.normal_z * conf.center_z;
    po_r[0] <= conf.normal_x * ray.ray_origin_x;
    po_r[1] <= conf.normal_y * ray.ray_origin_y;
    po_r[2] <= conf.normal_z * ray.ray_origin_z;
    pv_r[0] <= conf.normal_x * ray.ray_dir_x;
    pv_r[1] <= conf.normal_y * ray.ray_dir_y;
    pv_r[2] <= conf.normal_z * ray.ray_dir_z;
    ray1_r  <= ray;
    nc_r <= {{3{pc_r[0][63]}}, pc_r[0]} + {{3{pc_r[1][63]}}, pc_r[1]}
          + {{3{pc_r[2][63]}}, pc_r[2]};
    no_r <= {{3{po_r[0][63]}}, po_r[0]} + {{3{po_r[1][63]}}, po_r[1]}
          + {{3{po_r[2][63]}}, po_r[2]};
    den2_r <= {{2{pv_r[0][63]}}, pv_r[0]} + {{2{pv_r[1][63]}}, pv_r[1]}
            + {{2{pv_r[2][63]}}, pv_r[2]};
    ray2_r <= ray1_r;
    num_r  <= nc_r - no_r;
    den_r  <= den2_r;
    ray3_r <= ray2_r;
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      beat_r <= '0;
    end else begin
      v1_r   <= fire;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      beat_r <= beat_nxt;
    end
  end

  always_comb begin
    a        = num_r[66] ? 66'(-num_r) : num_r[65:0];
    den_abs  = den_r[65] ? 66'(-den_r) : den_r;
    b        = den_abs[63:0];
    beat_nxt = '0;
    beat_nxt.valid = v3_r;
    beat_nxt.ok  = (den_r != '0) && (num_r != '0) && (num_r[66] == den_r[65]);
    beat_nxt.sat = {13'b0, a} >= {b, 15'b0};
    beat_nxt.r   = {13'b0, a[65:ALOW]};
    beat_nxt.al  = a[ALOW-1:0];
    beat_nxt.b   = b;
    beat_nxt.q   = '0;
    beat_nxt.ray = ray3_r;
  end

  assign beat = beat_r;

endmodule

// ===== sv/rri_div_cell.sv =====
// one restoring division step, one quotient bit per cell
`timescale 1ns / 1ps
module rri_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rri_pkg::div_beat_t d_in,
  output rri_pkg::div_beat_t d_out
);
  import rri_pkg::*;

  div_beat_t out_r, out_nxt;
  logic [64:0] r2;
  logic [65:0] diff;
  logic ge;

  always_comb begin
    r2      = {d_in.r, d_in.al[ALOW-1]};
    diff    = {1'b0, r2} - {2'b0, d_in.b};
    ge      = !diff[65];
    out_nxt = d_in;
    out_nxt.r  = ge ? diff[63:0] : r2[63:0];
    out_nxt.q  = {d_in.q[QBITS-2:0], ge};
    out_nxt.al = {d_in.al[ALOW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else begin
      out_r <= out_nxt;
    end
  end

  assign d_out = out_r;

endmodule

// ===== sv/rri_back.sv =====
// hit point products, rectangle bounds test and result register
`timescale 1ns / 1ps
module rri_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rri_pkg::div_beat_t d_in,
  input  rri_pkg::conf_t     conf,
  output logic               strobe,
  output rri_pkg::res_t      res
);
  import rri_pkg::*;

  logic [QBITS-1:0] t;
  logic v1_r;
  logic tok_r;
  logic [QBITS-1:0] t_r;
  ray_t ray_r;
  logic signed [63:0] pv_r [3];
  logic signed [48:0] dx, dy, dz;
  logic [48:0] ax, ay, az;
  logic in_rect;
  logic strobe_r;
  res_t res_r, res_nxt;

  assign t = d_in.sat ? T_MAX : d_in.q;

  always_ff @(posedge clk) begin
    t_r     <= t;
    tok_r   <= d_in.ok && (t != '0);
    ray_r   <= d_in.ray;
    pv_r[0] <= $signed({1'b0, t}) * d_in.ray.ray_dir_x;
    pv_r[1] <= $signed({1'b0, t}) * d_in.ray.ray_dir_y;
    pv_r[2] <= $signed({1'b0, t}) * d_in.ray.ray_dir_z;
    res_r   <= res_nxt;
    if (!rst_n) begin
      v1_r     <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      v1_r     <= d_in.valid;
      strobe_r <= v1_r;
    end
  end

  always_comb begin
    dx = {{17{ray_r.ray_origin_x[31]}}, ray_r.ray_origin_x} + 49'(pv_r[0] >>> 16)
       - {{17{conf.center_x[31]}}, conf.center_x};
    dy = {{17{ray_r.ray_origin_y[31]}}, ray_r.ray_origin_y} + 49'(pv_r[1] >>> 16)
       - {{17{conf.center_y[31]}}, conf.center_y};
    dz = {{17{ray_r.ray_origin_z[31]}}, ray_r.ray_origin_z} + 49'(pv_r[2] >>> 16)
       - {{17{conf.center_z[31]}}, conf.center_z};
    ax = dx[48] ? 49'(-dx) : dx;
    ay = dy[48] ? 49'(-dy) : dy;
    az = dz[48] ? 49'(-dz) : dz;
    priority if (conf.normal_y == '0 && conf.normal_z == '0) begin
      in_rect = (ay < {18'b0, conf.half_width}) && (az < {18'b0, conf.half_height});
    end else if (conf.normal_x == '0 && conf.normal_y == '0) begin
      in_rect = (ax < {18'b0, conf.half_width}) && (ay < {18'b0, conf.half_height});
    end else begin
      in_rect = (ax < {18'b0, conf.half_width}) && (az < {18'b0, conf.half_height});
    end
    res_nxt.hit      = tok_r && in_rect;
    res_nxt.distance = res_nxt.hit ? t_r : '0;
  end

  assign strobe = strobe_r;
  assign res    = res_r;

endmodule

// ===== sv/ray_rectangle_intersect_top.sv =====
// top level of the ray against plane rectangle intersection block
//
// usage: raise start with a ray (origin, direction, signed Q16.16) on in_ray;
// the beat is taken at each clock edge with start high and busy low. busy is
// low whenever reset is released, so one ray can be taken every cycle.
// each ray gives exactly one result on out_res, valid for one cycle while
// out_strobe is high: hit and the distance t in unsigned Q15.16 (zero
// with no hit). stages: products, plane sums and their difference are
// registered in turn, then the magnitude and range check, 31 division
// cells (one quotient bit each), then the hit point products and the
// bounds test with the result register. throughput is one ray per cycle.
// configuration: cfg_we, cfg_idx, cfg_data write the plane normal, center
// and half extents; writes only while no ray is in flight.
// reset: synchronous, active low; clears the pipeline and loads the default
// plane (normal +z, center at origin, unit half extents). the receiver
// cannot stall, results are never held.
`timescale 1ns / 1ps
module ray_rectangle_intersect_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rri_pkg::ray_t  in_ray,
  output logic           out_strobe,
  output rri_pkg::res_t  out_res,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_idx,
  input  logic [31:0]    cfg_data
);
  import rri_pkg::*;

  localparam int NCELL = QBITS;

  conf_t conf_r;
  logic fire;
  div_beat_t chain [NCELL+1];

  assign busy = !rst_n;
  assign fire = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_r.normal_x    <= 32'sd0;
      conf_r.normal_y    <= 32'sd0;
      conf_r.normal_z    <= 32'sd65536;
      conf_r.center_x    <= 32'sd0;
      conf_r.center_y    <= 32'sd0;
      conf_r.center_z    <= 32'sd0;
      conf_r.half_width  <= 31'd65536;
      conf_r.half_height <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NORMAL_X: conf_r.normal_x    <= cfg_data;
        REG_NORMAL_Y: conf_r.normal_y    <= cfg_data;
        REG_NORMAL_Z: conf_r.normal_z    <= cfg_data;
        REG_CENTER_X: conf_r.center_x    <= cfg_data;
        REG_CENTER_Y: conf_r.center_y    <= cfg_data;
        REG_CENTER_Z: conf_r.center_z    <= cfg_data;
        REG_HALF_W:   conf_r.half_width  <= cfg_data[30:0];
        REG_HALF_H:   conf_r.half_height <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  rri_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .ray  (in_ray),
    .conf (conf_r),
    .beat (chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rri_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_in (chain[i]),
      .d_out(chain[i+1])
    );
  end

  rri_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (chain[NCELL]),
    .conf  (conf_r),
    .strobe(out_strobe),
    .res   (out_res)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(fire, 37))
    else $error("result beat without a matching ray");

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_res.hit) |-> (out_res.distance == '0))
    else $error("distance nonzero without hit");

  a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.hit) |-> (out_res.distance != '0))
    else $error("hit with zero distance");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result beat right after reset");

endmodule

// ===== verif/ray_rectangle_intersect_top_tb.sv =====
// self-checking testbench for the ray against plane rectangle intersection block
`timescale 1ns / 1ps
module ray_rectangle_intersect_top_tb;
  import rri_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 45;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ray_t in_ray;
  logic out_strobe;
  res_t out_res;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_data;

  conf_t plane;
  ray_t ray_pending[$];
  res_t hit_expected[$];
  int err_count;
  int gap_pct;
  longint cycle_count = 0;

  ray_rectangle_intersect_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_ray(in_ray),
    .out_strobe(out_strobe),
    .out_res(out_res),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t predict_hit(ray_t r);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic [127:0] mag_n;
    logic [127:0] mag_d;
    logic [127:0] quo;
    longint ts;
    longint dx;
    longint dy;
    longint dz;
    longint hw;
    longint hh;
    bit in_rect;
    res_t res;
    res = '0;
    num = longint'(plane.normal_x) * longint'(plane.center_x);
    num = num + longint'(plane.normal_y) * longint'(plane.center_y);
    num = num + longint'(plane.normal_z) * longint'(plane.center_z);
    num = num - longint'(plane.normal_x) * longint'(r.ray_origin_x);
    num = num - longint'(plane.normal_y) * longint'(r.ray_origin_y);
    num = num - longint'(plane.normal_z) * longint'(r.ray_origin_z);
    den = longint'(plane.normal_x) * longint'(r.ray_dir_x);
    den = den + longint'(plane.normal_y) * longint'(r.ray_dir_y);
    den = den + longint'(plane.normal_z) * longint'(r.ray_dir_z);
    if (den == 0 || num == 0 || (num < 0) != (den < 0)) return res;
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    if (mag_n >= (mag_d << 15)) quo = 128'(T_MAX);
    else quo = (mag_n << 16) / mag_d;
    if (quo == 0) return res;
    ts = longint'(quo[30:0]);
    dx = longint'(r.ray_origin_x) + ((ts * longint'(r.ray_dir_x)) >>> 16)
         - longint'(plane.center_x);
    dy = longint'(r.ray_origin_y) + ((ts * longint'(r.ray_dir_y)) >>> 16)
         - longint'(plane.center_y);
    dz = longint'(r.ray_origin_z) + ((ts * longint'(r.ray_dir_z)) >>> 16)
         - longint'(plane.center_z);
    dx = (dx < 0) ? -dx : dx;
    dy = (dy < 0) ? -dy : dy;
    dz = (dz < 0) ? -dz : dz;
    hw = longint'(plane.half_width);
    hh = longint'(plane.half_height);
    if (plane.normal_y == 0 && plane.normal_z == 0) in_rect = dy < hw && dz < hh;
    else if (plane.normal_x == 0 && plane.normal_y == 0) in_rect = dx < hw && dy < hh;
    else in_rect = dx < hw && dz < hh;
    if (in_rect) begin
      res.hit = 1'b1;
      res.distance = quo[30:0];
    end
    return res;
  endfunction

  task automatic report(string what);
    err_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_ray <= '0;
    end else begin
      if (start && !busy) hit_expected = {hit_expected, predict_hit(in_ray)};
      if ((!start || !busy) ) begin
        if (ray_pending.size() > 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          in_ray <= ray_pending.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (hit_expected.size() == 0) begin
        report($sformatf("unexpected result hit=%0b t=%0d", out_res.hit, out_res.distance));
      end else begin
        res_t want;
        want = hit_expected.pop_front();
        if (out_res.hit !== want.hit)
          report($sformatf("hit %0b, want %0b", out_res.hit, want.hit));
        if (out_res.distance !== want.distance)
          report($sformatf("distance %0d, want %0d", out_res.distance, want.distance));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_NORMAL_X: plane.normal_x = value;
      REG_NORMAL_Y: plane.normal_y = value;
      REG_NORMAL_Z: plane.normal_z = value;
      REG_CENTER_X: plane.center_x = value;
      REG_CENTER_Y: plane.center_y = value;
      REG_CENTER_Z: plane.center_z = value;
      REG_HALF_W: plane.half_width = value[30:0];
      REG_HALF_H: plane.half_height = value[30:0];
      default: ;
    endcase
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] hw, logic [31:0] hh);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_HALF_W, hw);
    write_reg(REG_HALF_H, hh);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (ray_pending.size() > 0 || start || hit_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    ray_t r;
    r.ray_origin_x = ox;
    r.ray_origin_y = oy;
    r.ray_origin_z = oz;
    r.ray_dir_x = vx;
    r.ray_dir_y = vy;
    r.ray_dir_z = vz;
    ray_pending = {ray_pending, r};
  endtask

  function automatic logic [31:0] small_val(int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  // aimed ray: pick a point near the center, step back along a random direction
  task automatic push_aimed();
    longint t;
    longint v[3];
    longint p[3];
    longint span_w;
    longint span_h;
    span_w = plane.half_width + plane.half_width / 2 + 2;
    span_h = plane.half_height + plane.half_height / 2 + 2;
    if (span_w > 64'h3fff_ffff) span_w = 64'h3fff_ffff;
    if (span_h > 64'h3fff_ffff) span_h = 64'h3fff_ffff;
    for (int i = 0; i < 3; i++) begin
      v[i] = $urandom_range(7) == 0 ? 0 : longint'($signed(small_val(1 << 18)));
      p[i] = $urandom_range(1)
             ? longint'($urandom_range(32'(span_w))) : -longint'($urandom_range(32'(span_h)));
    end
    p[0] += plane.center_x;
    p[1] += plane.center_y;
    p[2] += plane.center_z;
    t = $urandom_range(3) == 0 ? $urandom_range(32'h7fff_ffff) : $urandom_range(1 << 21);
    push_ray(32'(p[0] - ((t * v[0]) >>> 16)), 32'(p[1] - ((t * v[1]) >>> 16)),
             32'(p[2] - ((t * v[2]) >>> 16)), 32'(v[0]), 32'(v[1]), 32'(v[2]));
  endtask

  task automatic random_rays(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70) push_aimed();
      else push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_NORMAL_X;
    cfg_data = '0;
    err_count = 0;
    gap_pct = 0;
    plane.normal_x = 0;
    plane.normal_y = 0;
    plane.normal_z = 32'd65536;
    plane.center_x = 0;
    plane.center_y = 0;
    plane.center_z = 0;
    plane.half_width = 31'd65536;
    plane.half_height = 31'd65536;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default plane z = 0, square with unit half extents
    push_ray(0, 0, 32'h0002_0000, 0, 0, 32'hffff_0000);          // straight hit, t = 2
    push_ray(0, 0, 32'h0002_0000, 32'h0001_0000, 0, 0);          // parallel, zero denominator
    push_ray(0, 0, 0, 0, 0, 32'h0001_0000);                      // origin on plane
    push_ray(0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000);          // pointing away
    push_ray(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 32'hffff_0000); // on edge, strict miss
    push_ray(32'h0000_ffff, 32'hffff_0001, 32'h0001_0000, 0, 0, 32'hffff_0000);
    push_ray(0, 0, 32'h7fff_ffff, 0, 0, 32'hffff_ffff);          // saturated distance
    push_ray(0, 0, 32'h8000_0000, 0, 0, 32'h0000_0001);
    push_ray(0, 0, 32'h0000_0001, 0, 0, 32'h8000_0000);          // quotient truncates to zero
    push_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    push_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
             32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    push_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_ray(32'h0000_8000, 32'h0000_8000, 32'h0003_0000, 32'h0000_1000, 0, 32'hfffe_0000);
    wait_idle();

    for (int s = 0; s < 7; s++) begin
      gap_pct = s < 2 ? 20 : (s < 4 ? 76 : 0);
      case (s)
        0: set_plane(32'h0001_0000, 0, 0, 32'h0002_0000, 32'h0001_0000, 32'hffff_0000,
                     32'h0000_8000, 32'h0002_0000);
        1: set_plane(0, 0, 32'hfffe_0000, 32'hfff0_0000, 32'h0010_0000, 32'h0003_0000,
                     32'h0004_0000, 32'h0000_4000);
        2: set_plane(0, 32'h0001_0000, 0, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000,
                     32'h0002_0000, 32'h0002_0000);
        3: set_plane(small_val(1 << 17), small_val(1 << 17), small_val(1 << 17),
                     small_val(1 << 22), small_val(1 << 22), small_val(1 << 22),
                     $urandom_range(1 << 19), $urandom_range(1 << 19));
        4: set_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     32'hffff_ffff, 32'hffff_ffff);
        5: set_plane(32'h7fff_ffff, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     0, 0);
        default: set_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
      endcase
      random_rays(s == 6 ? 60 : 90);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
